// ===== hdl/bfs_pkg.sv =====
// bfs_pkg: shared types, constants and hash functions of the 64-bit bloom filter set
// no dependencies; imported by every module of the block
package bfs_pkg;

   // filter geometry
   localparam int FILTER_BITS = 64;
   localparam int HASH_COUNT  = 5;
   localparam int WORD_W      = 64;
   localparam int POS_W       = $clog2(FILTER_BITS);
   localparam int IDX_W       = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
   localparam int COUNT_W     = 7;

   // modulo reducer takes one digit of the hash word per cycle
   localparam int DIGIT_W     = 8;
   localparam int DIGIT_COUNT = WORD_W / DIGIT_W;
   localparam int STEP_MAX    = (DIGIT_COUNT > HASH_COUNT) ? DIGIT_COUNT : HASH_COUNT;
   localparam int STEP_W      = $clog2(STEP_MAX + 1);

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [WORD_W-1:0] SEED_RESET  = 64'hafb2041e061071db;
   localparam logic [WORD_W-1:0] FILTER_MASK = {WORD_W{1'b1}} >> (WORD_W - FILTER_BITS);

   // operation codes; unused codes behave as a query
   typedef enum logic [2:0] {
      OP_QUERY  = 3'd0,
      OP_INSERT = 3'd1,
      OP_LOAD   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_FILL   = 3'd4,
      OP_SEED   = 3'd5
   } op_type;

   // front sequencer states
   typedef enum logic [2:0] {
      FS_IDLE,
      FS_CHAIN,
      FS_REDUCE,
      FS_ORDER,
      FS_PUSH
   } front_state_type;

   // input beat
   typedef struct packed {
      logic [2:0]        operation;
      logic [WORD_W-1:0] operand;
   } req_type;

   // result beat
   typedef struct packed {
      logic [WORD_W-1:0]  filter_value;
      logic [COUNT_W-1:0] bit_count;
      logic               is_empty;
      logic               is_full;
      logic               holds_operand;
      logic               equals_operand;
      logic [WORD_W-1:0]  union_value;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0]        operation;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] set_mask;
   } work_type;

   // seed advance xorshift (29, 27, 37)
   function automatic logic [WORD_W-1:0] seed_shift(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] t;
      t = v ^ (v << 29);
      t = t ^ (t >> 27);
      t = t ^ (t << 37);
      return t;
   endfunction

   // key hash xorshift (12, 3, 13)
   function automatic logic [WORD_W-1:0] key_shift(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] t;
      t = v ^ (v << 12);
      t = t ^ (t >> 3);
      t = t ^ (t << 13);
      return t;
   endfunction

endpackage

// ===== hdl/bfs_front.sv =====
// bfs_front: accepts beats, keeps the hash seed and turns insert keys into a set mask
// depends on bfs_pkg; feeds bfs_queue
module bfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bfs_pkg::req_type  req_data,
   output logic              q_push,
   input  logic              q_full,
   output bfs_pkg::work_type q_data
);
   import bfs_pkg::*;

   front_state_type   state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   req_type           item_ff, item_in;
   logic [WORD_W-1:0] words_ff [HASH_COUNT];
   logic [WORD_W-1:0] words_in [HASH_COUNT];
   logic [POS_W-1:0]  pos_ff   [HASH_COUNT];
   logic [POS_W-1:0]  pos_in   [HASH_COUNT];
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;
   logic [POS_W-1:0]  pos_sel;
   logic [WORD_W-1:0] set_mask;

   assign accept  = (state_ff == FS_IDLE) && req_push;
   assign pos_sel = pos_ff[step_ff[IDX_W-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (req_push) begin
               if (req_data.operation == OP_INSERT) begin
                  state_in = (HASH_COUNT > 1) ? FS_CHAIN : FS_REDUCE;
               end else begin
                  state_in = FS_PUSH;
               end
            end
         end
         FS_CHAIN: begin
            if (step_ff == '0) state_in = FS_REDUCE;
         end
         FS_REDUCE: begin
            if (step_ff == '0) state_in = FS_ORDER;
         end
         FS_ORDER: begin
            if (step_ff == '0) state_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (!q_full) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_full = (state_ff != FS_IDLE);
      q_push   = (state_ff == FS_PUSH);
   end

   // set mask from the final positions
   always_comb begin
      set_mask = '0;
      if (item_ff.operation == OP_INSERT) begin
         for (int i = 0; i < HASH_COUNT; i++) begin
            set_mask = set_mask | (WORD_W'(1) << pos_ff[i]);
         end
      end
      q_data.operation = item_ff.operation;
      q_data.operand   = item_ff.operand;
      q_data.set_mask  = set_mask & FILTER_MASK;
   end

   // hash datapath: xorshift chain, digit-serial modulo, distinctness pass
   always_comb begin
      logic [POS_W:0] rem;
      logic [POS_W:0] lane_mod;
      seed_in  = seed_ff;
      item_in  = item_ff;
      words_in = words_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      rem      = '0;
      lane_mod = '0;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.operation == OP_SEED) seed_in = seed_shift(seed_ff);
               words_in[HASH_COUNT-1] = req_data.operand ^ seed_ff;
               for (int i = 0; i < HASH_COUNT; i++) pos_in[i] = '0;
               step_in = (HASH_COUNT > 1) ? STEP_W'(HASH_COUNT - 2)
                                          : STEP_W'(DIGIT_COUNT - 1);
            end
         end
         FS_CHAIN: begin
            // shift line: newest word at the top, first word ends at index 0
            for (int k = 0; k < HASH_COUNT - 1; k++) words_in[k] = words_ff[k+1];
            words_in[HASH_COUNT-1] = key_shift(words_ff[HASH_COUNT-1]);
            step_in = (step_ff == '0) ? STEP_W'(DIGIT_COUNT - 1) : step_ff - 1'b1;
         end
         FS_REDUCE: begin
            // each lane folds one digit into its remainder, msb first
            for (int i = 0; i < HASH_COUNT; i++) begin
               lane_mod = (POS_W + 1)'(FILTER_BITS - i);
               rem      = {1'b0, pos_ff[i]};
               for (int b = 0; b < DIGIT_W; b++) begin
                  rem = {rem[POS_W-1:0], words_ff[i][WORD_W-1-b]};
                  if (rem >= lane_mod) rem = rem - lane_mod;
               end
               pos_in[i]   = rem[POS_W-1:0];
               words_in[i] = words_ff[i] << DIGIT_W;
            end
            step_in = (step_ff == '0) ? STEP_W'(HASH_COUNT - 1) : step_ff - 1'b1;
         end
         FS_ORDER: begin
            // back to front: bump later positions at or above the current one
            for (int j = 0; j < HASH_COUNT; j++) begin
               if ((STEP_W'(j) > step_ff) && (pos_ff[j] >= pos_sel)) begin
                  pos_in[j] = pos_ff[j] + 1'b1;
               end
            end
            if (step_ff != '0) step_in = step_ff - 1'b1;
         end
         FS_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         seed_ff  <= SEED_RESET;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         step_ff  <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      words_ff <= words_in;
      pos_ff   <= pos_in;
   end

endmodule

// ===== hdl/bfs_queue.sv =====
// bfs_queue: short queue of classified items between front and back
// depends on bfs_pkg
module bfs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   output logic              q_full,
   input  bfs_pkg::work_type q_wdata,
   input  logic              q_pop,
   output logic              q_empty,
   output bfs_pkg::work_type q_rdata
);
   import bfs_pkg::*;

   work_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;
   assign q_rdata = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= q_wdata;
   end

endmodule

// ===== hdl/bfs_back.sv =====
// bfs_back: owns the filter word, applies items and builds result beats
// depends on bfs_pkg; drains bfs_queue
module bfs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  bfs_pkg::work_type q_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bfs_pkg::rsp_type  rsp_data
);
   import bfs_pkg::*;

   logic [WORD_W-1:0] filter_ff, filter_in;
   logic              stg_valid_ff, stg_valid_in;
   logic [WORD_W-1:0] stg_filter_ff;
   logic [WORD_W-1:0] stg_operand_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              stg_go;

   assign stg_go    = stg_valid_ff && (!out_valid_ff || rsp_pop);
   assign q_pop     = !q_empty && (!stg_valid_ff || stg_go);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // filter update
   always_comb begin
      filter_in = filter_ff;
      if (q_pop) begin
         case (q_data.operation)
            OP_INSERT: filter_in = (filter_ff | q_data.set_mask) & FILTER_MASK;
            OP_LOAD:   filter_in = q_data.operand & FILTER_MASK;
            OP_CLEAR:  filter_in = '0;
            OP_FILL:   filter_in = FILTER_MASK;
            default:   filter_in = filter_ff;
         endcase
      end
   end

   // stage valid and output valid
   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (q_pop)       stg_valid_in = 1'b1;
      else if (stg_go) stg_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (stg_go)       out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   // result fields from the staged filter
   always_comb begin
      out_in                = out_ff;
      if (stg_go) begin
         out_in.filter_value   = stg_filter_ff;
         out_in.bit_count      = COUNT_W'($countones(stg_filter_ff));
         out_in.is_empty       = (stg_filter_ff == '0);
         out_in.is_full        = (stg_filter_ff == FILTER_MASK);
         out_in.holds_operand  = ((stg_filter_ff | stg_operand_ff) == stg_filter_ff);
         out_in.equals_operand = (stg_filter_ff == stg_operand_ff);
         out_in.union_value    = stg_filter_ff | stg_operand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= '0;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         filter_ff    <= filter_in;
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         stg_filter_ff  <= filter_in;
         stg_operand_ff <= q_data.operand;
      end
      out_ff <= out_in;
   end

endmodule

// ===== hdl/bloom_filter_set_64bit_top.sv =====
// Insert: the front hash sequencer takes no new beat until the current one is pushed; it
// runs 4 chain steps, 8 modulo digit steps, 5 order steps and 1 push, and the push waits on a full queue.
// Other operations go from acceptance straight to the push; results then pass the queue, stage and output register.
// Back end and output register take one item per cycle while results are popped; a 2-deep queue parts front and back.
// Synchronous active-high reset: filter cleared, seed to its reset constant, queues empty.
// depends on bfs_pkg, bfs_front, bfs_queue, bfs_back
module bloom_filter_set_64bit_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bfs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bfs_pkg::rsp_type rsp_data
);
   import bfs_pkg::*;

   logic     fq_push, fq_full;
   work_type fq_wdata;
   logic     bq_pop, bq_empty;
   work_type bq_rdata;

   // hashing front
   bfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_full   (fq_full),
      .q_data   (fq_wdata)
   );

   // decoupling queue
   bfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (fq_push),
      .q_full  (fq_full),
      .q_wdata (fq_wdata),
      .q_pop   (bq_pop),
      .q_empty (bq_empty),
      .q_rdata (bq_rdata)
   );

   // filter back end
   bfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (bq_empty),
      .q_pop     (bq_pop),
      .q_data    (bq_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/bfs_checker.sv =====
// bfs_checker: port-level assertions for the bloom filter set top level
// depends on bfs_pkg; bound to bloom_filter_set_64bit_top
module bfs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input bfs_pkg::req_type req_data,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input bfs_pkg::rsp_type rsp_data
);
   import bfs_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result dropped or changed while waiting");

   // count, empty and full flags agree with the filter bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.bit_count == COUNT_W'($countones(rsp_data.filter_value)))
         && (rsp_data.is_empty == (rsp_data.filter_value == '0))
         && (rsp_data.is_full == (rsp_data.bit_count == COUNT_W'(FILTER_BITS)))))
      else $error("count or flags disagree with filter");

   // subset test agrees with the union
   a_subset: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.holds_operand
         == (rsp_data.union_value == rsp_data.filter_value)))
      else $error("subset flag disagrees with union");

   // filter never has bits above its width
   a_width: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.filter_value & ~FILTER_MASK) == '0))
      else $error("filter bit outside its width");

endmodule

bind bloom_filter_set_64bit_top bfs_checker u_bfs_checker (.*);

// ===== tb/testbench.sv =====
// testbench: drives bloom_filter_set_64bit_top through its push/full and empty/pop queue ports
// and checks every result beat against a predictor of the filter word and hash seed
// depends on bfs_pkg and the block's rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bfs_pkg::*;

   // codes the block treats as a query
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int STALL_MAX    = 14;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int ITEM_TOTAL   = 1050;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOLD_AT      = 450;
   localparam int DRAIN_AT     = 700;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_MAX    = 40;

   // filter and seed predictor with the queue of results still owed by the block
   class bloom_tracker;
      logic [WORD_W-1:0] filter_now;
      logic [WORD_W-1:0] seed_now;
      rsp_type           owed_results[$];
      int                errors;
      int                results_seen;
      int                op_seen[8];
      int                full_seen;
      int                subset_seen;
      int                equal_seen;

      function new();
         filter_now   = '0;
         seed_now     = SEED_RESET;
         errors       = 0;
         results_seen = 0;
         full_seen    = 0;
         subset_seen  = 0;
         equal_seen   = 0;
         foreach (op_seen[k]) op_seen[k] = 0;
      endfunction

      function int waiting();
         return owed_results.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
         if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
      endtask

      // apply one accepted request beat and queue the result it should produce
      function void take_request(req_type beat);
         logic [WORD_W-1:0] chain;
         logic [WORD_W-1:0] slot[HASH_COUNT];
         rsp_type           want;
         int                i;
         int                j;
         op_seen[beat.operation]++;
         case (beat.operation)
            OP_INSERT: begin
               // hash chain from key xor seed, each word reduced by a shrinking modulus
               chain = beat.operand ^ seed_now;
               for (i = 0; i < HASH_COUNT; i++) begin
                  slot[i] = chain % 64'(FILTER_BITS - i);
                  chain   = chain ^ (chain << 12);
                  chain   = chain ^ (chain >> 3);
                  chain   = chain ^ (chain << 13);
               end
               // back to front, push later positions past earlier ones so all are distinct
               for (i = HASH_COUNT - 1; i >= 0; i--)
                  for (j = i + 1; j < HASH_COUNT; j++)
                     if (slot[j] >= slot[i]) slot[j] = slot[j] + 1;
               for (i = 0; i < HASH_COUNT; i++)
                  filter_now = filter_now | (64'd1 << slot[i][5:0]);
               filter_now = filter_now & FILTER_MASK;
            end
            OP_LOAD:  filter_now = beat.operand & FILTER_MASK;
            OP_CLEAR: filter_now = '0;
            OP_FILL:  filter_now = FILTER_MASK;
            OP_SEED: begin
               seed_now = seed_now ^ (seed_now << 29);
               seed_now = seed_now ^ (seed_now >> 27);
               seed_now = seed_now ^ (seed_now << 37);
            end
            default: ;
         endcase

         // every result field is taken after the update
         want.filter_value   = filter_now;
         want.bit_count      = COUNT_W'($countones(filter_now));
         want.is_empty       = (filter_now == '0);
         want.is_full        = (filter_now == FILTER_MASK);
         want.holds_operand  = ((filter_now | beat.operand) == filter_now);
         want.equals_operand = (filter_now == beat.operand);
         want.union_value    = filter_now | beat.operand;
         if (want.is_full) full_seen++;
         if (want.holds_operand) subset_seen++;
         if (want.equals_operand) equal_seen++;
         owed_results.push_back(want);
      endfunction

      // compare one popped result beat with the oldest owed one
      task check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            report("result beat with nothing owed");
            return;
         end
         want = owed_results.pop_front();
         results_seen++;
         compare_field("filter_value", got.filter_value, want.filter_value);
         compare_field("bit_count", got.bit_count, want.bit_count);
         compare_field("is_empty", got.is_empty, want.is_empty);
         compare_field("is_full", got.is_full, want.is_full);
         compare_field("holds_operand", got.holds_operand, want.holds_operand);
         compare_field("equals_operand", got.equals_operand, want.equals_operand);
         compare_field("union_value", got.union_value, want.union_value);
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   bloom_tracker tracker;
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;
   int beats_sent   = 0;

   bloom_filter_set_64bit_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // comparison operand: equal, subset, superset, zero or unrelated
   function logic [WORD_W-1:0] probe_word();
      case ($urandom_range(0, 4))
         0: return tracker.filter_now;
         1: return tracker.filter_now & rand_word();
         2: return tracker.filter_now | (64'd1 << $urandom_range(0, 63));
         3: return '0;
         default: return rand_word();
      endcase
   endfunction

   // offer one beat, with an optional gap first, and wait for it to be taken
   task automatic send_beat(input logic [2:0] op, input logic [WORD_W-1:0] operand);
      req_type beat;
      beat.operation = op;
      beat.operand   = operand;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, STALL_MAX)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      do begin
         @(posedge clock);
      end while (req_full);
      tracker.take_request(beat);
      beats_sent++;
   endtask

   // mostly inserts with probes in between, plus a little of everything else
   task automatic send_random_beat();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 62)      send_beat(OP_INSERT, rand_word());
      else if (roll < 80) send_beat(OP_QUERY, probe_word());
      else if (roll < 86) send_beat(OP_SEED, rand_word());
      else if (roll < 89) send_beat(OP_LOAD, rand_word() & rand_word());
      else if (roll < 91) send_beat(OP_FILL, rand_word());
      else if (roll < 93) send_beat(OP_CLEAR, rand_word());
      else if (roll < 96) send_beat(OP_INSERT, tracker.seed_now ^ (64'd1 << $urandom_range(0, 63)));
      else send_beat($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, probe_word());
   endtask

   // stimulus and end of run
   initial begin : stimulus
      int run_len;
      bit held_done;
      bit drained_done;
      held_done    = 1'b0;
      drained_done = 1'b0;
      tracker      = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every operation, hash corners, full and unused codes
      send_beat(OP_QUERY, '0);
      send_beat(OP_QUERY, '1);
      send_beat(OP_INSERT, '0);
      send_beat(OP_INSERT, '1);
      send_beat(OP_QUERY, tracker.filter_now);
      send_beat(OP_SEED, '0);
      send_beat(OP_INSERT, '0);
      send_beat(OP_INSERT, tracker.seed_now);
      send_beat(OP_INSERT, tracker.seed_now ^ 64'h3f);
      send_beat(OP_LOAD, '1);
      send_beat(OP_INSERT, rand_word());
      send_beat(OP_QUERY, '1);
      send_beat(OP_LOAD, 64'h8000_0000_0000_0001);
      send_beat(OP_QUERY, 64'h8000_0000_0000_0000);
      send_beat(OP_QUERY, 64'h8000_0000_0000_0003);
      send_beat(OP_CLEAR, '1);
      send_beat(OP_QUERY, '0);
      send_beat(OP_FILL, '0);
      send_beat(OP_SPARE_A, 64'h5555_5555_5555_5555);
      send_beat(OP_SPARE_B, 64'haaaa_aaaa_aaaa_aaaa);
      send_beat(OP_CLEAR, '0);
      send_beat(OP_SEED, '1);
      send_beat(OP_SEED, '1);
      send_beat(OP_INSERT, 64'h0123_4567_89ab_cdef);
      send_beat(OP_LOAD, rand_word());

      // random runs, each from a cleared, sparse or carried-over filter
      while (beats_sent < ITEM_TOTAL) begin
         run_len = $urandom_range(20, 140);
         case ($urandom_range(0, 3))
            0: send_beat(OP_CLEAR, rand_word());
            1: send_beat(OP_LOAD, rand_word() & rand_word() & rand_word());
            default: ;
         endcase
         for (int k = 0; k < run_len && beats_sent < ITEM_TOTAL; k++) begin
            send_random_beat();
            idle_on = (beats_sent < ITEM_TOTAL - TAIL_ITEMS);
            // long receiver hold while the sender keeps offering
            if (!held_done && beats_sent >= HOLD_AT) begin
               hold_request = 1'b1;
               held_done    = 1'b1;
            end
            // sender waits until every owed result is back
            if (!drained_done && beats_sent >= DRAIN_AT) begin
               req_push <= 1'b0;
               while (tracker.waiting() != 0) @(posedge clock);
               drained_done = 1'b1;
            end
         end
      end

      req_push <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request beats: %0d insert, %0d query, %0d load, %0d clear, %0d fill, %0d seed, %0d unused code",
               beats_sent, tracker.op_seen[OP_INSERT], tracker.op_seen[OP_QUERY],
               tracker.op_seen[OP_LOAD], tracker.op_seen[OP_CLEAR], tracker.op_seen[OP_FILL],
               tracker.op_seen[OP_SEED],
               tracker.op_seen[OP_SPARE_A] + tracker.op_seen[OP_SPARE_B]);
      $display("%0d result beats checked; full filter %0d times, subset %0d, exact match %0d; %0d mismatches",
               tracker.results_seen, tracker.full_seen, tracker.subset_seen,
               tracker.equal_seen, tracker.errors);
      if (tracker.errors == 0 && tracker.waiting() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: pop with random stall bursts and one long hold
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) tracker.check_result(rsp_data);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, STALL_MAX);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // end the run when no beat moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("timeout: %0d cycles without a beat", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bfs_pkg.sv
hdl/bfs_front.sv
hdl/bfs_queue.sv
hdl/bfs_back.sv
hdl/bloom_filter_set_64bit_top.sv
hdl/bfs_checker.sv
tb/testbench.sv
